[rtl/core/ilv_pkg.sv]
package ilv_pkg;

  localparam int MAX_ITEMS = 512;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int IN_W      = 64;

  localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK,
    S_FINISH
  } state_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic dup;
  } tok_t;

  typedef struct packed {
    logic signed [IN_W-1:0] value;
    logic                   last_item;
  } item_t;

  typedef struct packed {
    status_t item_status;
    logic    list_valid;
    logic    list_ascending;
    logic    list_done;
  } result_t;

endpackage

[rtl/core/ilv_cell.sv]
module ilv_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ilv_pkg::tok_t                tok_in,
  input  logic [ilv_pkg::VAL_W-1:0]    query,
  input  logic                         occupied,
  input  logic                         append_here,
  output ilv_pkg::tok_t                tok_out
);
  import ilv_pkg::*;

  logic [VAL_W-1:0] entry;
  logic             hit;

  // Only a stored entry may match; cells past the fill point hold stale data
  assign hit = tok_in.valid && occupied && (entry == query);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.dup   <= tok_in.valid && (tok_in.dup || hit);
    end
  end

  // Append at the first free cell; every stored cell has been checked by now
  always_ff @(posedge clk) begin
    if (tok_in.valid && append_here && !tok_in.dup) begin
      entry <= query;
    end
  end

endmodule

[rtl/core/int_list_validator_top.sv]
// Channel  Dir  Payload       Handshake
// item     in   ilv item_t    item_valid / item_ready
// result   out  ilv result_t  result_valid / result_ready
//
// An in-range value is captured on transfer, then a search token walks the full row
// of MAX_ITEMS cells, one cell per cycle, and a final step forms the verdicts.
// An out-of-range value skips the walk and goes straight to the final step.
// One item is in flight at a time; item_ready is high only while idle, but a
// finished result may still wait in the output register meanwhile.
// Reset is synchronous; the stored values need none, the fill count bounds reads.
// A stalled result holds the block in its final step until the slot frees.
module int_list_validator_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ilv_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output ilv_pkg::result_t result
);
  import ilv_pkg::*;

  state_t state, state_next;

  // List state
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] prev;
  logic                    have_prev;
  logic                    asc;
  logic                    err;

  // Item held while it is worked on
  logic [VAL_W-1:0] q_sat;
  logic             q_range;
  logic             q_order_bad;
  logic             q_last;
  logic             q_dup;

  // Accept-side decode
  logic                    accept;
  logic                    in_range_bad;
  logic [VAL_W-1:0]        sat;
  logic                    order_bad;
  logic signed [IN_W-1:0]  prev_ext;

  // Control
  logic    launch;
  logic    slot_free;
  logic    commit;
  logic    walk_done;
  status_t status_next;
  logic    full;

  tok_t tok [MAX_ITEMS+1];

  assign accept = item_valid && item_ready;

  // Out of range when the upper bits are not all copies of bit 31
  assign in_range_bad = !((&item.value[IN_W-1:VAL_W-1]) || !(|item.value[IN_W-1:VAL_W-1]));

  always_comb begin
    if (in_range_bad) begin
      sat = item.value[IN_W-1] ? INT_MIN : INT_MAX;
    end else begin
      sat = item.value[VAL_W-1:0];
    end
  end

  assign prev_ext  = {{(IN_W-VAL_W){prev[VAL_W-1]}}, prev};
  assign order_bad = have_prev && !(item.value > prev_ext);

  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign walk_done = tok[MAX_ITEMS].valid;
  assign slot_free = !result_valid || result_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = in_range_bad ? S_FINISH : S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    item_ready = 1'b0;
    launch     = 1'b0;
    commit     = 1'b0;
    unique case (state)
      S_IDLE:   item_ready = 1'b1;
      S_LAUNCH: launch     = 1'b1;
      S_WALK:   ;
      S_FINISH: commit     = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on transfer, the search verdict at the end of the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      q_sat       <= sat;
      q_range     <= in_range_bad;
      q_order_bad <= order_bad;
      q_last      <= item.last_item;
      q_dup       <= 1'b0;
    end else if (state == S_WALK && walk_done) begin
      q_dup <= tok[MAX_ITEMS].dup;
    end
  end

  // Status priority: range, then duplicate, then store full
  always_comb begin
    if (q_range) begin
      status_next = STAT_RANGE;
    end else if (q_dup) begin
      status_next = STAT_DUP;
    end else if (full) begin
      status_next = STAT_FULL;
    end else begin
      status_next = STAT_OK;
    end
  end

  // Row of cells: token enters cell 0 in the cycle after the transfer
  assign tok[0].valid = launch;
  assign tok[0].dup   = 1'b0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ilv_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .tok_in      (tok[i]),
      .query       (q_sat),
      .occupied    (CNT_W'(i) < count),
      .append_here (CNT_W'(i) == count),
      .tok_out     (tok[i+1])
    );
  end

  // Commit the verdicts; clear the list after its last item
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev      <= '0;
      have_prev <= 1'b0;
      asc       <= 1'b1;
      err       <= 1'b0;
    end else if (commit) begin
      if (q_last) begin
        count     <= '0;
        prev      <= '0;
        have_prev <= 1'b0;
        asc       <= 1'b1;
        err       <= 1'b0;
      end else begin
        if (status_next == STAT_OK) begin
          count <= count + CNT_W'(1);
        end
        prev      <= q_sat;
        have_prev <= 1'b1;
        asc       <= asc && !q_order_bad;
        err       <= err || (status_next != STAT_OK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.item_status    <= status_next;
      result.list_valid     <= !(err || (status_next != STAT_OK));
      result.list_ascending <= asc && !q_order_bad;
      result.list_done      <= q_last;
    end
  end

  // The token only leaves the row during a walk
  a_exit_in_walk: assert property (@(posedge clk) disable iff (rst)
    walk_done |-> state == S_WALK)
    else $error("search token left the row outside a walk");

  // The fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond store depth");

  // Any error status makes the list verdict invalid
  a_err_verdict: assert property (@(posedge clk) disable iff (rst)
    commit |=> (result.item_status == STAT_OK) || !result.list_valid)
    else $error("error status with list still valid");

  // Closing a list empties the store
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (commit && q_last) |=> (count == '0) && !have_prev)
    else $error("list state not cleared after last item");

endmodule

[sim/tb_top.sv]
module tb_top;
  import ilv_pkg::*;

  // Long receiver hold-off: long enough for the block to finish one value,
  // park its result, take the next value and finish that one too.
  localparam int HOLD_CYCLES  = 3 * MAX_ITEMS;
  localparam int RANDOM_ITEMS = 360;
  // Worst case for one in-range value is a full walk of the row; add a margin
  // before declaring the block quiet at the end.
  localparam int DRAIN_CYCLES = MAX_ITEMS + 32;

  localparam longint I32_LO = longint'(INT_MIN);
  localparam longint I32_HI = longint'(INT_MAX);

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // Verdicts still owed by the block, oldest first
  result_t pending_verdicts[$];
  int      mismatches = 0;

  // Running copy of the list state, advanced on every item transfer
  logic signed [VAL_W-1:0] kept_vals[MAX_ITEMS];
  int                      kept_count = 0;
  logic signed [VAL_W-1:0] prior_val  = '0;
  bit                      rising_so_far = 1'b1;
  bit                      list_faulted  = 1'b0;
  bit                      have_prior    = 1'b0;

  // Sender burst bookkeeping
  int burst_left = 0;

  // Receiver hold-off request: the test bumps hold_asks, the receiver
  // notices the change and counts the stretch out itself.
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  bit [15:0] rx_tick = '0;

  longint boundary_vals[6] = '{
    I32_LO, I32_HI, I32_HI + 1, I32_LO - 1,
    64'sh8000_0000_0000_0000, 64'sh7fff_ffff_ffff_ffff
  };

  int_list_validator_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the verdict for one value and advance the list state.
  // Out-of-range values skip the store and the duplicate search, but still
  // take part in the order check at full width and leave a saturated copy
  // behind as the previous value.
  function automatic result_t judge_value(input item_t it);
    longint                  v;
    logic signed [VAL_W-1:0] sat;
    status_t                 st;
    bit                      dup;
    result_t                 r;
    v   = longint'(it.value);
    st  = STAT_OK;
    dup = 1'b0;
    if (v < I32_LO || v > I32_HI) begin
      st  = STAT_RANGE;
      sat = (v < I32_LO) ? INT_MIN : INT_MAX;
    end else begin
      sat = v[VAL_W-1:0];
      for (int j = 0; j < kept_count; j++)
        if (kept_vals[j] == sat) dup = 1'b1;
      if (dup)
        st = STAT_DUP;
      else if (kept_count >= MAX_ITEMS)
        st = STAT_FULL;
      else begin
        kept_vals[kept_count] = sat;
        kept_count++;
      end
    end
    if (have_prior && !(v > longint'(prior_val)))
      rising_so_far = 1'b0;
    prior_val  = sat;
    have_prior = 1'b1;
    if (st != STAT_OK)
      list_faulted = 1'b1;
    r.item_status    = st;
    r.list_valid     = !list_faulted;
    r.list_ascending = rising_so_far;
    r.list_done      = it.last_item;
    // Clear the list state once the closing value has been judged
    if (it.last_item) begin
      kept_count    = 0;
      prior_val     = '0;
      rising_so_far = 1'b1;
      list_faulted  = 1'b0;
      have_prior    = 1'b0;
    end
    return r;
  endfunction

  function automatic item_t make_item(input longint v, input bit fin);
    item_t it;
    it.value     = v;
    it.last_item = fin;
    return it;
  endfunction

  task automatic note_mismatch(input string what, input result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status=%0d valid=%0b asc=%0b done=%0b,",
               $realtime, what, want.item_status, want.list_valid, want.list_ascending,
               want.list_done,
               " got status=%0d valid=%0b asc=%0b done=%0b",
               result.item_status, result.list_valid,
               result.list_ascending, result.list_done);
  endtask

  // Compare one result transfer against the oldest outstanding verdict
  task automatic check_result();
    result_t want;
    if (pending_verdicts.size() == 0) begin
      want = '0;
      note_mismatch("result with nothing outstanding", want);
    end else begin
      want = pending_verdicts.pop_front();
      if (result.item_status    !== want.item_status    ||
          result.list_valid     !== want.list_valid     ||
          result.list_ascending !== want.list_ascending ||
          result.list_done      !== want.list_done)
        note_mismatch("verdict mismatch", want);
    end
  endtask

  // Offer one value and hold it until the transfer. Called at a rising edge;
  // returns at the edge of the transfer, or after the gap that ends a burst.
  // Keep valid high between back-to-back items rather than dropping it.
  task automatic send_item(input item_t it);
    int gap;
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_verdicts.push_back(judge_value(it));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      // Mostly short gaps; now and then one long enough to leave the block idle
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(400, 1100) : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
  endtask

  // Receiver: check every result transfer, then choose next cycle's ready.
  // Alternate smooth stretches (always ready) with rough ones (random stalls),
  // and serve any long hold-off the test has asked for.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_result();
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      rx_tick = rx_tick + 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (rx_tick[8]) begin
        result_ready <= ($urandom_range(0, 2) != 0);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Boundaries of the range, saturation of out-of-range values, duplicates,
  // order breaks, single-value lists and the first-value-always-ascending rule.
  task automatic test_directed_edges();
    // Clean ascending walk across the whole 32-bit range
    send_item(make_item(I32_LO, 1'b0));
    send_item(make_item(-1, 1'b0));
    send_item(make_item(0, 1'b0));
    send_item(make_item(1, 1'b0));
    send_item(make_item(I32_HI, 1'b1));
    // Just above the range first, then INT_MAX, which is not above the
    // saturated previous value; then just below the range
    send_item(make_item(I32_HI + 1, 1'b0));
    send_item(make_item(I32_HI, 1'b0));
    send_item(make_item(I32_LO - 1, 1'b1));
    // 64-bit extremes: both out of range, but ascending at full width
    send_item(make_item(64'sh8000_0000_0000_0000, 1'b0));
    send_item(make_item(64'sh7fff_ffff_ffff_ffff, 1'b1));
    // Single-value list
    send_item(make_item(42, 1'b1));
    // Duplicate, then a drop in order, then a recovery that cannot undo it
    send_item(make_item(5, 1'b0));
    send_item(make_item(5, 1'b0));
    send_item(make_item(3, 1'b0));
    send_item(make_item(7, 1'b1));
    // Out-of-range value in mid-list keeps the order, then INT_MAX breaks it
    send_item(make_item(10, 1'b0));
    send_item(make_item(I32_HI + 5, 1'b0));
    send_item(make_item(I32_HI, 1'b1));
  endtask

  // Fill the store with MAX_ITEMS distinct values, then push past it.
  // Stored values sit on even offsets in their own bucket, so odd offsets
  // are guaranteed new; check that duplicate and range still take priority.
  task automatic test_store_full();
    longint base, v, kept_pick;
    int     pick;
    pick      = $urandom_range(0, MAX_ITEMS - 1);
    kept_pick = 0;
    for (int n = 0; n < MAX_ITEMS; n++) begin
      base = I32_LO + longint'(n) * 64'sd8388608;
      v    = base + 2 * $urandom_range(0, 4194303);
      if (n == pick) kept_pick = v;
      send_item(make_item(v, 1'b0));
    end
    base = I32_LO + longint'($urandom_range(0, MAX_ITEMS - 1)) * 64'sd8388608;
    send_item(make_item(base + 2 * $urandom_range(0, 4194303) + 1, 1'b0));
    send_item(make_item(kept_pick, 1'b0));
    send_item(make_item(boundary_vals[$urandom_range(2, 5)], 1'b0));
    base = I32_LO + longint'($urandom_range(0, MAX_ITEMS - 1)) * 64'sd8388608;
    send_item(make_item(base + 2 * $urandom_range(0, 4194303) + 1, 1'b1));
  endtask

  // Hold the receiver off while values keep coming, so a finished result
  // parks in the output register, the next value finishes behind it, and
  // the block has to refuse further input.
  task automatic test_receiver_hold();
    hold_asks <= hold_asks + 1;
    // Offer the whole list back to back so no sender gap lets the hold run out
    burst_left = 8;
    send_item(make_item(20, 1'b0));
    send_item(make_item(30, 1'b0));
    send_item(make_item(I32_HI + 9, 1'b0));
    send_item(make_item(40, 1'b0));
    send_item(make_item(30, 1'b0));
    send_item(make_item(50, 1'b1));
  endtask

  // Random lists: most are tidy ascending runs with random content, the rest
  // mix in duplicates, drops, raw 32-bit and 64-bit values and boundaries.
  task automatic test_random_lists();
    longint prev, v;
    longint list_vals[$];
    int     len, k, sent;
    bit     tidy;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      tidy = ($urandom_range(0, 9) < 6);
      list_vals.delete();
      prev = 0;
      for (int n = 0; n < len; n++) begin
        k = tidy ? 0 : $urandom_range(0, 99);
        if (n == 0)
          v = longint'($signed($urandom())) >>> 1;
        else if (k < 55)
          v = prev + $urandom_range(1, 1 << 22);
        else if (k < 70 && list_vals.size() > 0)
          v = list_vals[$urandom_range(0, list_vals.size() - 1)];
        else if (k < 80)
          v = prev - $urandom_range(0, 1000);
        else if (k < 90)
          v = longint'($signed($urandom()));
        else if (k < 96)
          v = {$urandom(), $urandom()};
        else
          v = boundary_vals[$urandom_range(0, 5)];
        if (v >= I32_LO && v <= I32_HI) list_vals.push_back(v);
        send_item(make_item(v, n == len - 1));
        prev = v;
        sent++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_store_full();
    test_receiver_hold();
    test_random_lists();

    // Stop offering, let every owed verdict arrive, then watch for strays
    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[int_list_validator_top.f]
rtl/core/ilv_pkg.sv
rtl/core/ilv_cell.sv
rtl/core/int_list_validator_top.sv
sim/tb_top.sv
